// ===== src/keyframe_vec2_interpolator_core_macros.svh =====
// Assertion helpers shared by the keyframe interpolator RTL.
`ifndef KEYFRAME_VEC2_INTERPOLATOR_CORE_MACROS_SVH
`define KEYFRAME_VEC2_INTERPOLATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KVI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyframe interpolator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KVI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyframe interpolator: next-cycle check failed");

`endif

// ===== src/kvi_pkg.sv =====
package kvi_pkg;

  localparam int MAX_KEYS = 16;
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int DATA_W   = 32;

  // Fraction is unsigned Q0.16 plus one integer bit so that 1.0 fits.
  localparam int QUO_BITS = 16;
  localparam int STEP_W   = $clog2(QUO_BITS);
  localparam int FRAC_W   = QUO_BITS + 1;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << QUO_BITS;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = DATA_W + 2;
  localparam int MUL_B_W = FRAC_W + 2;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef struct packed {
    logic              ease;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] t;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

// ===== src/kvi_ram.sv =====
module kvi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/kvi_mul.sv =====
module kvi_mul (
  input  logic                                 clk,
  input  kvi_pkg::mul_op_t                     op,
  output logic signed [kvi_pkg::MUL_P_W-1:0]   prod
);

  logic signed [kvi_pkg::MUL_P_W-1:0] a_ext;
  logic signed [kvi_pkg::MUL_P_W-1:0] b_ext;

  always_comb begin
    a_ext = kvi_pkg::MUL_P_W'(op.a);
    b_ext = kvi_pkg::MUL_P_W'(op.b);
  end

  always_ff @(posedge clk) begin
    prod <= a_ext * b_ext;
  end

endmodule

// ===== src/kvi_div.sv =====
module kvi_div (
  input  logic                          clk,
  input  logic                          rst,
  input  kvi_pkg::div_req_t             req,
  output logic                          done,
  output logic [kvi_pkg::QUO_BITS-1:0]  quot
);

  logic [kvi_pkg::DATA_W-1:0] rem;
  logic [kvi_pkg::DATA_W-1:0] den;
  logic [kvi_pkg::STEP_W-1:0] step;
  logic                       running;
  logic [kvi_pkg::DATA_W:0]   rem_sh;
  logic [kvi_pkg::DATA_W:0]   rem_sub;
  logic                       take;

  // Restoring division of num * 2^16 by den; the caller guarantees num < den.
  always_comb begin
    rem_sh  = {rem, 1'b0};
    rem_sub = rem_sh - {1'b0, den};
    take    = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        step    <= '0;
        rem     <= req.num;
        den     <= req.den;
      end else if (running) begin
        rem  <= take ? rem_sub[kvi_pkg::DATA_W-1:0] : rem_sh[kvi_pkg::DATA_W-1:0];
        quot <= {quot[kvi_pkg::QUO_BITS-2:0], take};
        step <= step + 1'b1;
        if (step == kvi_pkg::STEP_W'(kvi_pkg::QUO_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/keyframe_vec2_interpolator_core.sv =====
// Channel   | Signals                                            | Handshake
// ----------+----------------------------------------------------+-----------------------
// command   | mode entry_index entry_time entry_x entry_y        | start high, busy low
//           | entry_ease query_time                              |
// result    | result_x result_y segment                          | done, one cycle only
// config    | cfg_data (key_count)                               | cfg_valid and cfg_ready
//
// A load takes effect at its transfer edge and leaves busy low.
// An evaluate keeps busy high through the scan state, which steps past each key passed,
// a setup state, the divider when the query falls inside a segment, the smoothstep
// states (square, cube, ease) when the segment eases, then the blend states (x, y, finish).
// Results cannot be stalled: done rises as busy falls, and a new command may be
// transferred in that cycle. Reset sets key_count to 1; the key RAM is not cleared.
`include "keyframe_vec2_interpolator_core_macros.svh"

module keyframe_vec2_interpolator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [kvi_pkg::IDX_W-1:0]           entry_index,
  input  logic [kvi_pkg::DATA_W-1:0]          entry_time,
  input  logic signed [kvi_pkg::DATA_W-1:0]   entry_x,
  input  logic signed [kvi_pkg::DATA_W-1:0]   entry_y,
  input  logic                                entry_ease,
  input  logic [kvi_pkg::DATA_W-1:0]          query_time,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kvi_pkg::CNT_W-1:0]           cfg_data,
  output logic                                done,
  output logic signed [kvi_pkg::DATA_W-1:0]   result_x,
  output logic signed [kvi_pkg::DATA_W-1:0]   result_y,
  output logic [kvi_pkg::IDX_W-1:0]           segment
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIFF,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_EASE,
    ST_BLX,
    ST_BLY,
    ST_FINISH
  } state_t;

  state_t state;

  logic [kvi_pkg::CNT_W-1:0]  key_count;
  logic [kvi_pkg::CNT_W-1:0]  n_clamp;
  logic [kvi_pkg::CNT_W-1:0]  n_keys;
  logic [kvi_pkg::CNT_W-1:0]  scan_idx;
  logic [kvi_pkg::CNT_W-1:0]  scan_dec;
  logic [kvi_pkg::DATA_W-1:0] q_time;
  logic [kvi_pkg::DATA_W-1:0] t_lo;
  logic [kvi_pkg::DATA_W-1:0] x_lo;
  logic [kvi_pkg::DATA_W-1:0] y_lo;
  logic [kvi_pkg::DATA_W-1:0] x_hi;
  logic [kvi_pkg::DATA_W-1:0] y_hi;
  logic                       ease_lo;
  logic                       use_div;
  logic [kvi_pkg::IDX_W-1:0]  seg;
  logic [kvi_pkg::DATA_W:0]   dx;
  logic [kvi_pkg::DATA_W:0]   dy;
  logic [kvi_pkg::FRAC_W-1:0] frac;
  logic [kvi_pkg::FRAC_W:0]   ease_g;

  logic                       cmd_xfer;
  logic                       ram_we;
  kvi_pkg::key_t              ram_wkey;
  logic [kvi_pkg::IDX_W-1:0]  ram_raddr;
  logic [kvi_pkg::KEY_W-1:0]  ram_rdata;
  kvi_pkg::key_t              rd_key;
  logic                       scan_end;
  logic                       scan_pass;

  kvi_pkg::div_req_t                  div_req;
  logic                               div_done;
  logic [kvi_pkg::QUO_BITS-1:0]       div_quot;
  kvi_pkg::mul_op_t                   mul_op;
  logic signed [kvi_pkg::MUL_P_W-1:0] mul_prod;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cmd_xfer  = start && !busy;
  assign ram_we    = cmd_xfer && (mode == kvi_pkg::MODE_LOAD);
  assign rd_key    = kvi_pkg::key_t'(ram_rdata);
  assign scan_end  = (scan_idx == n_keys);
  assign scan_pass = (q_time >= rd_key.t);
  assign scan_dec  = scan_idx - 1'b1;

  always_comb begin
    ram_wkey.ease = entry_ease;
    ram_wkey.y    = entry_y;
    ram_wkey.x    = entry_x;
    ram_wkey.t    = entry_time;
  end

  always_comb begin
    if (key_count == '0) begin
      n_clamp = kvi_pkg::CNT_W'(1);
    end else if (key_count > kvi_pkg::CNT_W'(kvi_pkg::MAX_KEYS)) begin
      n_clamp = kvi_pkg::CNT_W'(kvi_pkg::MAX_KEYS);
    end else begin
      n_clamp = key_count;
    end
  end

  // The read port runs one key ahead of the compare, so each scan cycle retires a key.
  always_comb begin
    if (state == ST_SCAN) begin
      ram_raddr = scan_idx[kvi_pkg::IDX_W-1:0] + 1'b1;
    end else begin
      ram_raddr = '0;
    end
  end

  // The divider only runs when the query falls inside a segment: at or past its lower key, before its upper key.
  always_comb begin
    div_req.start = (state == ST_SCAN) && !scan_end && !scan_pass && (scan_idx != '0);
    div_req.num   = q_time - t_lo;
    div_req.den   = rd_key.t - t_lo;
  end

  assign ease_g = (kvi_pkg::FRAC_W + 1)'(3) * {1'b0, kvi_pkg::FRAC_ONE} - {frac, 1'b0};

  always_comb begin
    mul_op.a = '0;
    mul_op.b = '0;
    unique case (state)
      ST_SQ: begin
        mul_op.a = kvi_pkg::MUL_A_W'(frac);
        mul_op.b = kvi_pkg::MUL_B_W'(frac);
      end
      ST_CUBE: begin
        mul_op.a = kvi_pkg::MUL_A_W'(mul_prod[kvi_pkg::DATA_W:0]);
        mul_op.b = kvi_pkg::MUL_B_W'(ease_g);
      end
      ST_BLX: begin
        mul_op.a = kvi_pkg::MUL_A_W'(signed'(dx));
        mul_op.b = kvi_pkg::MUL_B_W'(frac);
      end
      ST_BLY: begin
        mul_op.a = kvi_pkg::MUL_A_W'(signed'(dy));
        mul_op.b = kvi_pkg::MUL_B_W'(frac);
      end
      default: begin
        mul_op.a = '0;
        mul_op.b = '0;
      end
    endcase
  end

  kvi_ram #(
    .WIDTH (kvi_pkg::KEY_W),
    .DEPTH (kvi_pkg::MAX_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_index),
    .wdata (ram_wkey),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kvi_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  kvi_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      key_count <= kvi_pkg::CNT_W'(1);
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        key_count <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_xfer && (mode == kvi_pkg::MODE_EVAL)) begin
            q_time   <= query_time;
            n_keys   <= n_clamp;
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            // Query at or past the last key: hold the last value.
            x_hi    <= x_lo;
            y_hi    <= y_lo;
            seg     <= scan_dec[kvi_pkg::IDX_W-1:0];
            use_div <= 1'b0;
            state   <= ST_DIFF;
          end else if (scan_pass) begin
            t_lo     <= rd_key.t;
            x_lo     <= rd_key.x;
            y_lo     <= rd_key.y;
            ease_lo  <= rd_key.ease;
            scan_idx <= scan_idx + 1'b1;
          end else if (scan_idx == '0) begin
            // Query before the first key: both ends collapse onto key 0.
            x_lo    <= rd_key.x;
            y_lo    <= rd_key.y;
            x_hi    <= rd_key.x;
            y_hi    <= rd_key.y;
            ease_lo <= rd_key.ease;
            seg     <= '0;
            use_div <= 1'b0;
            state   <= ST_DIFF;
          end else begin
            x_hi    <= rd_key.x;
            y_hi    <= rd_key.y;
            seg     <= scan_dec[kvi_pkg::IDX_W-1:0];
            use_div <= 1'b1;
            state   <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          dx   <= {x_hi[kvi_pkg::DATA_W-1], x_hi} - {x_lo[kvi_pkg::DATA_W-1], x_lo};
          dy   <= {y_hi[kvi_pkg::DATA_W-1], y_hi} - {y_lo[kvi_pkg::DATA_W-1], y_lo};
          frac <= kvi_pkg::FRAC_ONE;
          if (use_div) begin
            state <= ST_DIV;
          end else if (ease_lo) begin
            state <= ST_SQ;
          end else begin
            state <= ST_BLX;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            frac  <= {1'b0, div_quot};
            state <= ease_lo ? ST_SQ : ST_BLX;
          end
        end
        ST_SQ: begin
          state <= ST_CUBE;
        end
        ST_CUBE: begin
          state <= ST_EASE;
        end
        ST_EASE: begin
          // f^2 * (3 - 2f) scaled down by 2^32 and truncated gives the eased fraction.
          frac  <= mul_prod[kvi_pkg::FRAC_W + 2 * kvi_pkg::QUO_BITS - 1:2 * kvi_pkg::QUO_BITS];
          state <= ST_BLX;
        end
        ST_BLX: begin
          state <= ST_BLY;
        end
        ST_BLY: begin
          result_x <= x_lo + mul_prod[kvi_pkg::DATA_W + kvi_pkg::QUO_BITS - 1:kvi_pkg::QUO_BITS];
          state    <= ST_FINISH;
        end
        ST_FINISH: begin
          result_y <= y_lo + mul_prod[kvi_pkg::DATA_W + kvi_pkg::QUO_BITS - 1:kvi_pkg::QUO_BITS];
          segment  <= seg;
          done     <= 1'b1;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `KVI_ASSERT_NXT(a_finish_gives_done, clk, rst, state == ST_FINISH, done)
  `KVI_ASSERT_NXT(a_done_single_cycle, clk, rst, done, !done)
  `KVI_ASSERT_IMP(a_scan_in_range, clk, rst, state == ST_SCAN, scan_idx <= n_keys)
  `KVI_ASSERT_IMP(a_segment_in_use, clk, rst, done, {1'b0, segment} < n_keys)
  `KVI_ASSERT_NXT(a_load_stays_idle, clk, rst, cmd_xfer && (mode == kvi_pkg::MODE_LOAD),
                  state == ST_IDLE)

endmodule

// ===== sim/keyframe_vec2_interpolator_core_tb.sv =====
`timescale 1ns / 1ps

module keyframe_vec2_interpolator_core_tb;
  import kvi_pkg::*;

  localparam logic EASE_LINEAR  = 1'b0;
  localparam logic EASE_SMOOTH  = 1'b1;
  localparam int   RANDOM_ITEMS = 1800;
  localparam int   CYCLE_LIMIT  = 1_500_000;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [IDX_W-1:0]         seg;
  } frame_point_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     mode;
  logic [IDX_W-1:0]         entry_index;
  logic [DATA_W-1:0]        entry_time;
  logic signed [DATA_W-1:0] entry_x;
  logic signed [DATA_W-1:0] entry_y;
  logic                     entry_ease;
  logic [DATA_W-1:0]        query_time;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_data;
  logic                     done;
  logic signed [DATA_W-1:0] result_x;
  logic signed [DATA_W-1:0] result_y;
  logic [IDX_W-1:0]         segment;

  // Shadow copy of the key table and the key count register.
  logic [DATA_W-1:0] shadow_time [MAX_KEYS];
  logic [DATA_W-1:0] shadow_x    [MAX_KEYS];
  logic [DATA_W-1:0] shadow_y    [MAX_KEYS];
  logic              shadow_ease [MAX_KEYS];
  logic [CNT_W-1:0]  shadow_count;

  frame_point_t expected_points[$];
  int           mismatches  = 0;
  int           items_sent  = 0;
  int unsigned  cycle_count = 0;
  bit           steady      = 1'b0;

  always #2 clk = ~clk;

  keyframe_vec2_interpolator_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .entry_index (entry_index),
    .entry_time  (entry_time),
    .entry_x     (entry_x),
    .entry_y     (entry_y),
    .entry_ease  (entry_ease),
    .query_time  (query_time),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .done        (done),
    .result_x    (result_x),
    .result_y    (result_y),
    .segment     (segment)
  );

  function automatic int active_keys();
    if (shadow_count < 1) return 1;
    if (shadow_count > MAX_KEYS) return MAX_KEYS;
    return int'(shadow_count);
  endfunction

  // lo + floor((hi - lo) * w / 2^16), with w in [0, 1.0].
  function automatic logic [DATA_W-1:0] lerp_q16(input logic [DATA_W-1:0] lo_v,
                                                 input logic [DATA_W-1:0] hi_v,
                                                 input logic [63:0] w);
    longint base;
    longint diff;
    longint prod;
    base = longint'($signed(lo_v));
    diff = longint'($signed(hi_v)) - base;
    prod = diff * longint'(w);
    return DATA_W'(base + (prod >>> QUO_BITS));
  endfunction

  function automatic frame_point_t interpolate_at(input logic [DATA_W-1:0] qt);
    int           n;
    int           i;
    int           lo;
    int           hi;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [63:0]  frac;
    logic [63:0]  f2;
    logic [63:0]  f3;
    frame_point_t pt;
    n = active_keys();
    i = 0;
    while (i < n && qt >= shadow_time[i]) i++;
    hi = (i == n) ? n - 1 : i;
    lo = (i == 0) ? 0 : i - 1;
    // Collapsed bracket (before the first or from the last key) means the end value.
    frac = 64'(FRAC_ONE);
    if (hi != lo && shadow_time[hi] > shadow_time[lo]) begin
      num  = (qt >= shadow_time[lo]) ? 64'(qt - shadow_time[lo]) : 64'd0;
      den  = 64'(shadow_time[hi] - shadow_time[lo]);
      frac = (num << QUO_BITS) / den;
      if (frac > 64'(FRAC_ONE)) frac = 64'(FRAC_ONE);
    end
    if (shadow_ease[lo] == EASE_SMOOTH) begin
      f2   = frac * frac;
      f3   = f2 * frac;
      frac = (((64'd3 * f2) << QUO_BITS) - 64'd2 * f3) >> (2 * QUO_BITS);
      if (frac > 64'(FRAC_ONE)) frac = 64'(FRAC_ONE);
    end
    pt.x   = lerp_q16(shadow_x[lo], shadow_x[hi], frac);
    pt.y   = lerp_q16(shadow_y[lo], shadow_y[hi], frac);
    pt.seg = IDX_W'(lo);
    return pt;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  function automatic logic [DATA_W-1:0] random_coord();
    if ($urandom_range(0, 9) < 7) return $urandom;
    return DATA_W'($urandom_range(0, 2000)) - DATA_W'(1000);
  endfunction

  // Query times cluster around key times so that every bracket gets exercised.
  function automatic logic [DATA_W-1:0] pick_query();
    int n;
    int j;
    n = active_keys();
    j = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0: return shadow_time[j];
      1: return shadow_time[j] - 1;
      2: return shadow_time[j] + 1;
      3: return '0;
      4: return '1;
      5: return $urandom;
      default: begin
        if (j + 1 < n) return $urandom_range(shadow_time[j + 1], shadow_time[j]);
        return shadow_time[j] + DATA_W'($urandom_range(0, 1000));
      end
    endcase
  endfunction

  task automatic issue_command(input logic cmd_mode, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] t, input logic [DATA_W-1:0] x,
                               input logic [DATA_W-1:0] y, input logic e,
                               input logic [DATA_W-1:0] q);
    int gap;
    start       <= 1'b1;
    mode        <= cmd_mode;
    entry_index <= idx;
    entry_time  <= t;
    entry_x     <= x;
    entry_y     <= y;
    entry_ease  <= e;
    query_time  <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd_mode == MODE_LOAD) begin
      shadow_time[idx] = t;
      shadow_x[idx]    = x;
      shadow_y[idx]    = y;
      shadow_ease[idx] = e;
    end else begin
      expected_points.push_back(interpolate_at(q));
    end
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start       <= 1'b0;
      mode        <= 1'($urandom);
      entry_index <= IDX_W'($urandom);
      entry_time  <= $urandom;
      entry_x     <= $urandom;
      entry_y     <= $urandom;
      entry_ease  <= 1'($urandom);
      query_time  <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_key(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] t,
                          input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                          input logic e);
    issue_command(MODE_LOAD, idx, t, x, y, e, $urandom);
  endtask

  task automatic evaluate_at(input logic [DATA_W-1:0] q);
    issue_command(MODE_EVAL, IDX_W'($urandom), $urandom, $urandom, $urandom,
                  1'($urandom), q);
  endtask

  task automatic set_key_count(input logic [CNT_W-1:0] value);
    start <= 1'b0;
    while (expected_points.size() != 0 || busy) @(posedge clk);
    // A load leaves no result behind, so give the sequencer time to settle.
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_count = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_ascending_table();
    longint t;
    longint stride;
    int     spread;
    spread = $urandom_range(0, 2);
    t = longint'($urandom >> $urandom_range(0, 31));
    for (int k = 0; k < MAX_KEYS; k++) begin
      load_key(IDX_W'(k), DATA_W'(t), random_coord(), random_coord(), 1'($urandom));
      case (spread)
        0:       stride = $urandom_range(0, 16);
        1:       stride = $urandom_range(1, 65536);
        default: stride = $urandom_range(1, 32'h0FFF_FFFF);
      endcase
      t = t + stride;
      if (t > longint'(32'hFFFF_FFFF)) t = longint'(32'hFFFF_FFFF);
    end
  endtask

  // Table with extreme values, a duplicate key time and the last key at the top of time.
  task automatic test_extreme_table();
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic              e;
    for (int k = 0; k < MAX_KEYS; k++) begin
      if (k == 0) t = 32'h0001_0000;
      else if (k == 1) t = 32'h0003_0000;
      else if (k < 4) t = 32'h0005_0000;
      else if (k == MAX_KEYS - 1) t = 32'hFFFF_FFFF;
      else t = DATA_W'(k) << 20;
      x = (k < 3) ? ((k % 2 == 1) ? 32'h7FFF_FFFF : 32'h8000_0000) : $urandom;
      y = (k < 3) ? ((k % 2 == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF) : $urandom;
      e = (k == 0) ? EASE_SMOOTH : (k == 1) ? EASE_LINEAR : 1'(k);
      load_key(IDX_W'(k), t, x, y, e);
    end
    // Key count is still at its reset value of one here.
    evaluate_at(32'h0002_0000);
  endtask

  task automatic test_segment_cases();
    set_key_count(CNT_W'(MAX_KEYS));
    evaluate_at(32'h0000_0000);
    evaluate_at(32'h0001_0000);
    evaluate_at(32'h0002_0000);
    evaluate_at(32'h0004_0000);
    evaluate_at(32'h0005_0000);
    evaluate_at(32'h00A8_0000);
    evaluate_at(32'hFFFF_FFFE);
    evaluate_at(32'hFFFF_FFFF);
  endtask

  task automatic test_count_limits();
    set_key_count('0);
    evaluate_at(32'h0004_0000);
    set_key_count('1);
    evaluate_at(32'hFFFF_FFFF);
    evaluate_at(32'h0004_0000);
  endtask

  task automatic test_random_playback();
    int first;
    int phase_len;
    int r;
    int j;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       set_key_count('0);
        1:       set_key_count(CNT_W'(1));
        2:       set_key_count(CNT_W'(2));
        3:       set_key_count(CNT_W'(MAX_KEYS));
        4:       set_key_count('1);
        5:       set_key_count(CNT_W'($urandom_range(MAX_KEYS + 1, 30)));
        default: set_key_count(CNT_W'($urandom_range(1, MAX_KEYS)));
      endcase
      load_ascending_table();
      phase_len = $urandom_range(40, 150);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        j = $urandom_range(0, MAX_KEYS - 1);
        if (r < 78) begin
          evaluate_at(pick_query());
        end else if (r < 88) begin
          // New value and easing for a key, its time kept.
          load_key(IDX_W'(j), shadow_time[j], random_coord(), random_coord(),
                   1'($urandom));
        end else if (r < 95) begin
          load_key(IDX_W'(j), $urandom, $urandom, $urandom, 1'($urandom));
        end else begin
          load_ascending_table();
        end
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    frame_point_t want;
    if (!rst && done) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result: result_x %h result_y %h segment %0d",
               result_x, result_y, segment);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (result_x !== want.x) begin
          $error("result_x: expected %h, actual %h", want.x, result_x);
          mismatches++;
        end
        if (result_y !== want.y) begin
          $error("result_y: expected %h, actual %h", want.y, result_y);
          mismatches++;
        end
        if (segment !== want.seg) begin
          $error("segment: expected %0d, actual %0d", want.seg, segment);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("keyframe_vec2_interpolator_core: mismatch");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    mode         <= MODE_LOAD;
    entry_index  <= '0;
    entry_time   <= '0;
    entry_x      <= '0;
    entry_y      <= '0;
    entry_ease   <= EASE_LINEAR;
    query_time   <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    shadow_count = CNT_W'(1);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_extreme_table();
    test_segment_cases();
    test_count_limits();
    test_random_playback();
    start <= 1'b0;
    while (expected_points.size() != 0 || busy) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("keyframe_vec2_interpolator_core: match");
    end else begin
      $display("keyframe_vec2_interpolator_core: mismatch");
    end
    $finish;
  end

endmodule
